### src/fftf_pkg.sv
package fftf_pkg;

    localparam int RADIX_W      = 24;
    localparam int LEN_BITS_DEF = 24;
    localparam int MAX_RESULTS  = 16;
    localparam int NUM_PREF     = 6;
    localparam int TRIAL_START  = 11;
    localparam int PREF_IDX_W   = 3;

    function automatic logic [2:0] pref_radix(input logic [PREF_IDX_W-1:0] idx);
        logic [2:0] r;
        case (idx)
            3'd0:    r = 3'd7;
            3'd1:    r = 3'd6;
            3'd2:    r = 3'd5;
            3'd3:    r = 3'd4;
            3'd4:    r = 3'd3;
            3'd5:    r = 3'd2;
            default: r = 3'd2;
        endcase
        return r;
    endfunction

endpackage

### src/fftf_div.sv
module fftf_div
    import fftf_pkg::*;
#(
    parameter int W = LEN_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);

    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvs;
    logic [W:0]       w_trial;
    logic [W:0]       w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("Divider started while busy.");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("Divider done without a finished iteration.");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("Divider did not start after a start request.");

endmodule

### src/fft_length_factorizer.sv
// Every trial division runs through the shared restoring divider, and each emitted factor
// passes through the output state, where an output stall can hold it.
// The work grows with the number of divisions tried; a prime near 2^24 needs about 2050.
// Throughput: one transaction at a time; o_stall is high from acceptance to the last factor.
// Reset: synchronous, active low; the sequencer returns to idle and any plan is dropped.
module fft_length_factorizer
    import fftf_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [LEN_BITS-1:0] i_length,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [RADIX_W-1:0]  o_radix,
    output logic                o_last,
    output logic                o_error
);

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_NEXT = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [LEN_BITS-1:0]   r_rest, n_rest;
    logic [LEN_BITS-1:0]   r_f, n_f;
    logic [PREF_IDX_W-1:0] r_ridx, n_ridx;
    logic [LEN_BITS-1:0]   r_pend, n_pend;
    logic                  r_have_pend, n_have_pend;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_finish, n_finish;
    logic [RADIX_W-1:0]    r_radix, n_radix;
    logic                  r_last, n_last;
    logic                  r_error, n_error;

    logic                  w_pref;
    logic [LEN_BITS-1:0]   w_divisor;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [LEN_BITS-1:0]   w_quot;
    logic [LEN_BITS-1:0]   w_rem;
    logic                  w_found;
    logic [LEN_BITS-1:0]   w_factor;
    logic                  w_rest_one;

    assign w_pref      = r_ridx < PREF_IDX_W'(NUM_PREF);
    assign w_divisor   = w_pref ? LEN_BITS'(pref_radix(r_ridx)) : r_f;
    assign w_rest_one  = r_rest == LEN_BITS'(1);
    assign w_div_start = (r_state == S_NEXT) && !w_rest_one;

    fftf_div #(
        .W (LEN_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rest),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_rest      = r_rest;
        n_f         = r_f;
        n_ridx      = r_ridx;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        n_count     = r_count;
        n_finish    = r_finish;
        n_radix     = r_radix;
        n_last      = r_last;
        n_error     = r_error;
        w_found     = 1'b0;
        w_factor    = w_divisor;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_length == '0) begin
                        n_radix  = '0;
                        n_last   = 1'b1;
                        n_error  = 1'b1;
                        n_finish = 1'b1;
                        n_state  = S_OUT;
                    end else if (i_length == LEN_BITS'(1)) begin
                        n_radix  = RADIX_W'(1);
                        n_last   = 1'b1;
                        n_error  = 1'b0;
                        n_finish = 1'b1;
                        n_state  = S_OUT;
                    end else begin
                        n_rest      = i_length;
                        n_f         = LEN_BITS'(TRIAL_START);
                        n_ridx      = '0;
                        n_have_pend = 1'b0;
                        n_count     = '0;
                        n_finish    = 1'b0;
                        n_state     = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                if (w_rest_one) begin
                    n_radix  = RADIX_W'(r_pend);
                    n_last   = 1'b1;
                    n_error  = 1'b0;
                    n_finish = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_pref) begin
                        if (w_rem == '0) begin
                            w_found  = 1'b1;
                            w_factor = w_divisor;
                            n_rest   = w_quot;
                        end else begin
                            n_ridx = r_ridx + 1'b1;
                        end
                    end else if (w_quot < r_f) begin
                        w_found  = 1'b1;
                        w_factor = r_rest;
                        n_rest   = LEN_BITS'(1);
                    end else if (w_rem == '0) begin
                        w_found  = 1'b1;
                        w_factor = r_f;
                        n_rest   = w_quot;
                    end else begin
                        n_f = r_f + LEN_BITS'(2);
                    end

                    n_state = S_NEXT;
                    if (w_found) begin
                        if (!r_have_pend) begin
                            n_pend      = w_factor;
                            n_have_pend = 1'b1;
                            n_count     = CNT_W'(1);
                        end else if (r_count == CNT_W'(MAX_RESULTS)) begin
                            n_radix  = RADIX_W'(r_pend);
                            n_last   = 1'b1;
                            n_error  = 1'b1;
                            n_finish = 1'b1;
                            n_state  = S_OUT;
                        end else begin
                            n_radix = RADIX_W'(r_pend);
                            n_last  = 1'b0;
                            n_error = 1'b0;
                            n_pend  = w_factor;
                            n_count = r_count + 1'b1;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = r_finish ? S_IDLE : S_NEXT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_pend <= 1'b0;
            r_count     <= '0;
            r_finish    <= 1'b0;
            r_ridx      <= '0;
        end else begin
            r_state     <= n_state;
            r_have_pend <= n_have_pend;
            r_count     <= n_count;
            r_finish    <= n_finish;
            r_ridx      <= n_ridx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_f     <= n_f;
        r_pend  <= n_pend;
        r_radix <= n_radix;
        r_last  <= n_last;
        r_error <= n_error;
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_state == S_OUT;
    assign o_radix = r_radix;
    assign o_last  = r_last;
    assign o_error = r_error;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RESULTS))
        else $error("Factor count exceeds the result limit.");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_last)
        else $error("Error flagged on a factor that is not the last one.");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("Divider result arrived outside the divide state.");

    a_trial_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && !w_pref |-> r_f[0])
        else $error("Trial divisor is even.");

endmodule

### test/fft_plan_checker.sv
`timescale 1ns / 100ps

module fft_plan_checker
    import fftf_pkg::*;
#(
    parameter int LEN_W = LEN_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [LEN_W-1:0]   i_in_length,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [RADIX_W-1:0] i_radix,
    input  logic               i_last,
    input  logic               i_error,
    output int                 o_fault_count = 0,
    output int                 o_pending = 0
);

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               last;
        logic               error;
    } t_factor;

    t_factor expected_factors [$];
    longint unsigned preferred_radix [NUM_PREF] = '{7, 6, 5, 4, 3, 2};
    int plan_count;
    bit plan_full;

    task automatic report_fault(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fault_count++;
    endtask

    function automatic void append_expected(input t_factor item);
        expected_factors.insert(expected_factors.size(), item);
    endfunction

    function automatic void add_factor(input longint unsigned f);
        if (plan_count >= MAX_RESULTS) begin
            plan_full = 1'b1;
        end else begin
            append_expected('{radix: f[RADIX_W-1:0], last: 1'b0, error: 1'b0});
            plan_count++;
        end
    endfunction

    function automatic void plan_length(input logic [LEN_W-1:0] len);
        longint unsigned rest;
        longint unsigned f;
        rest = len;
        plan_count = 0;
        plan_full = 1'b0;
        if (rest == 0) begin
            append_expected('{radix: RADIX_W'(0), last: 1'b1, error: 1'b1});
            return;
        end
        if (rest == 1) begin
            append_expected('{radix: RADIX_W'(1), last: 1'b1, error: 1'b0});
            return;
        end
        for (int i = 0; i < NUM_PREF && rest > 1; i++) begin
            while (rest % preferred_radix[i] == 0) begin
                rest = rest / preferred_radix[i];
                add_factor(preferred_radix[i]);
            end
        end
        f = TRIAL_START;
        while (rest > 1) begin
            if (f * f > rest) begin
                add_factor(rest);
                rest = 1;
            end else if (rest % f == 0) begin
                rest = rest / f;
                add_factor(f);
            end else begin
                f += 2;
            end
        end
        expected_factors[expected_factors.size()-1].last = 1'b1;
        if (plan_full) begin
            expected_factors[expected_factors.size()-1].error = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_factor want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_factors.size() == 0) begin
                    report_fault($sformatf("unexpected result transaction, radix %0d", i_radix));
                end else begin
                    want = expected_factors.pop_front();
                    if (i_radix !== want.radix) begin
                        report_fault($sformatf("radix %0d, expected %0d", i_radix, want.radix));
                    end
                    if (i_last !== want.last) begin
                        report_fault($sformatf("last %b, expected %b", i_last, want.last));
                    end
                    if (i_error !== want.error) begin
                        report_fault($sformatf("error %b, expected %b", i_error, want.error));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                plan_length(i_in_length);
            end
        end
        o_pending = expected_factors.size();
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
    import fftf_pkg::*;

    localparam int LEN_W = LEN_BITS_DEF;
    localparam longint unsigned MAX_LEN = (64'd1 << LEN_W) - 1;
    localparam int LONG_HOLD = 3000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [LEN_W-1:0]   i_length = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [RADIX_W-1:0] o_radix;
    logic               o_last;
    logic               o_error;
    int                 fault_count;
    int                 pending;
    bit                 calm = 1'b0;
    bit                 hold_request = 1'b0;

    logic [LEN_W-1:0] corner_lengths [24] = '{
        0, 1, 2, 3, 4, 5, 6, 7, 12, 36, 5040, 11, 13, 121, 143, 8191, 90046,
        14348907, 8388608, 10077696, 16777215, 16777213, 16752649, 16744463
    };
    int unsigned smooth_factor [12] = '{2, 3, 4, 5, 6, 7, 8, 9, 11, 13, 17, 19};

    fft_length_factorizer #(
        .LEN_BITS(LEN_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_length(i_length),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_radix (o_radix),
        .o_last  (o_last),
        .o_error (o_error)
    );

    fft_plan_checker #(
        .LEN_W(LEN_W)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_length  (i_length),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_radix      (o_radix),
        .i_last       (o_last),
        .i_error      (o_error),
        .o_fault_count(fault_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Most lengths are products of small factors so that trial division stays short;
    // a few are drawn over the full range.
    function automatic logic [LEN_W-1:0] random_length();
        int unsigned kind;
        longint unsigned f;
        longint unsigned v;
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
            return LEN_W'($urandom());
        end
        if (kind < 10) begin
            return LEN_W'($urandom_range(0, 40));
        end
        v = 1;
        repeat ($urandom_range(1, 16)) begin
            f = smooth_factor[$urandom_range(0, 11)];
            if (v * f <= MAX_LEN) begin
                v = v * f;
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            f = $urandom_range(5, 2047) | 1;
            if (v * f <= MAX_LEN) begin
                v = v * f;
            end
        end
        return v[LEN_W-1:0];
    endfunction

    task automatic offer_length(input logic [LEN_W-1:0] v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_length <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin : sink
        int w;
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                w = calm ? 0 : $urandom_range(0, 4);
                if (w > 0) begin
                    i_stall <= 1'b1;
                    repeat (w) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (corner_lengths[i]) begin
            offer_length(corner_lengths[i]);
        end
        wait_drained();
        repeat (100) offer_length(random_length());
        // The receiver holds off while the sender keeps offering, so the block backs up.
        hold_request = 1'b1;
        repeat (6) offer_length(random_length());
        calm = 1'b1;
        repeat (50) offer_length(random_length());
        calm = 1'b0;
        repeat (130) offer_length(random_length());
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("fft_length_factorizer regression: pass");
        end else begin
            $display("fft_length_factorizer regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000_000;
        $display("fft_length_factorizer regression: fail");
        $finish;
    end

endmodule

### filelist.f
src/fftf_pkg.sv
src/fftf_div.sv
src/fft_length_factorizer.sv
test/fft_plan_checker.sv
test/tb.sv
